>>> rtl/core/multi_waveform_lfo_core_macros.svh
// assertion macros shared by the lfo core
`ifndef MULTI_WAVEFORM_LFO_CORE_MACROS_SVH
`define MULTI_WAVEFORM_LFO_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MLFO_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lfo core check failed");

// next-cycle implication, checked outside reset
`define MLFO_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lfo core check failed");

`endif

>>> rtl/core/mlfo_pkg.sv
// shared types and constants of the lfo core
`default_nettype none

package mlfo_pkg;

    localparam int PHASE_W   = 24;
    localparam int MAX_BLOCK = 256;
    localparam int BLEN_W    = 9;
    localparam int REM_W     = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int SAMPLE_W  = 16;
    localparam int INTERP_W  = 25;
    localparam int RS_W      = 48;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_W     = 26;
    localparam int PROD_W    = 2 * MUL_W;

    // lcg multiplier 0x5DEECE66D split at bit 24
    localparam logic [23:0] LCG_LO  = 24'hECE66D;
    localparam logic [10:0] LCG_HI  = 11'h5DE;
    localparam logic [RS_W-1:0] LCG_INC = 48'd11;

    // 0.225 in q16
    localparam logic [15:0] SINE_K = 16'd14746;

    localparam logic CMD_RUN     = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef enum logic [2:0] {
        WAVE_SINE   = 3'd0,
        WAVE_TRI    = 3'd1,
        WAVE_SAW_UP = 3'd2,
        WAVE_SAW_DN = 3'd3,
        WAVE_SQUARE = 3'd4,
        WAVE_RANDOM = 3'd5
    } wave_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVE        = 3'd0,
        REG_PHASE_INC   = 3'd1,
        REG_DEPTH       = 3'd2,
        REG_INTERP_STEP = 3'd3,
        REG_SEED        = 3'd4
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_IDLE,
        ST_DRAW0,
        ST_DRAW1,
        ST_DRAW2,
        ST_DRAW3,
        ST_SIN0,
        ST_SIN1,
        ST_SIN2,
        ST_SIN3,
        ST_RND_CHK,
        ST_RND_VAL,
        ST_DMUL,
        ST_DRES,
        ST_ADV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]         wave;
        logic [PHASE_W-1:0] phase_inc;
        logic [15:0]        depth;
        logic [23:0]        interp_step;
        logic [RS_W-1:0]    seed;
        logic               seed_load;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/mlfo_mul.sv
// shared signed multiplier with registered product
`default_nettype none

module mlfo_mul (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic signed [mlfo_pkg::MUL_W-1:0]    a,
    input  wire logic signed [mlfo_pkg::MUL_W-1:0]    b,
    output logic signed [mlfo_pkg::PROD_W-1:0]        prod
);

    // product register, loaded when an operation is issued
    always_ff @(posedge aclk) begin
        if (en) begin
            prod <= a * b;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mlfo_cfg.sv
// configuration register file of the lfo core
`default_nettype none

module mlfo_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              idle,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mlfo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mlfo_pkg::RS_W-1:0]         cfg_data,
    output mlfo_pkg::cfg_t                         cfg
);

    logic [2:0]                   wave_reg;
    logic [mlfo_pkg::PHASE_W-1:0] inc_reg;
    logic [15:0]                  depth_reg;
    logic [23:0]                  step_reg;
    logic [mlfo_pkg::RS_W-1:0]    seed_reg;
    logic                         seed_load_reg;
    logic                         wr;

    assign cfg_ready = idle;
    assign wr        = cfg_valid && cfg_ready;

    // register writes, seed write flags a reload of the generator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg      <= 3'd0;
            inc_reg       <= mlfo_pkg::PHASE_W'(1000);
            depth_reg     <= 16'd32768;
            step_reg      <= 24'hFFFFFF;
            seed_reg      <= mlfo_pkg::RS_W'(1);
            seed_load_reg <= 1'b0;
        end else begin
            seed_load_reg <= 1'b0;
            if (wr) begin
                case (cfg_index)
                    mlfo_pkg::REG_WAVE:        wave_reg  <= cfg_data[2:0];
                    mlfo_pkg::REG_PHASE_INC:   inc_reg   <= cfg_data[mlfo_pkg::PHASE_W-1:0];
                    mlfo_pkg::REG_DEPTH:       depth_reg <= cfg_data[15:0];
                    mlfo_pkg::REG_INTERP_STEP: step_reg  <= cfg_data[23:0];
                    mlfo_pkg::REG_SEED: begin
                        seed_reg      <= cfg_data;
                        seed_load_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign cfg.wave        = wave_reg;
    assign cfg.phase_inc   = inc_reg;
    assign cfg.depth       = depth_reg;
    assign cfg.interp_step = step_reg;
    assign cfg.seed        = seed_reg;
    assign cfg.seed_load   = seed_load_reg;

endmodule

`default_nettype wire

>>> rtl/core/multi_waveform_lfo_core.sv
// lfo core: sequencer and datapath around one shared multiplier
// run beat: accept in ST_IDLE, then ST_SIN0..3 for sine, ST_RND_CHK (and ST_RND_VAL) for smoothed random,
//   ST_DMUL and ST_DRES for depth scaling, ST_ADV for each further sample (block_length - 1), then ST_OUT
// every random draw runs the 48-bit lcg in 3 partial products, in ST_DRAW0 to ST_DRAW3
// restart beat: two draws, then the result; one item in flight at a time
// reset: phase and interpolation cleared, seed 1 loaded and drawn twice before ready
// a seed write reloads the generator the same way and blocks input until both draws are done
`default_nettype none

`include "multi_waveform_lfo_core_macros.svh"

module multi_waveform_lfo_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_command,
    input  wire logic [mlfo_pkg::BLEN_W-1:0]          s_block_length,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [mlfo_pkg::SAMPLE_W-1:0]      m_lfo_value,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [mlfo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mlfo_pkg::RS_W-1:0]            cfg_data
);

    mlfo_pkg::cfg_t cfg;

    mlfo_pkg::state_t state_reg, state_next;
    mlfo_pkg::state_t ret_reg, ret_next;
    logic                                  pair_reg, pair_next;
    logic                                  dcnt_reg, dcnt_next;
    logic [mlfo_pkg::PHASE_W-1:0]          phase_reg, phase_next;
    logic [mlfo_pkg::INTERP_W-1:0]         interp_reg, interp_next;
    logic [mlfo_pkg::REM_W-1:0]            rem_reg, rem_next;
    logic [mlfo_pkg::RS_W-1:0]             rs_reg, rs_next;
    logic [mlfo_pkg::RS_W-1:0]             acc_reg, acc_next;
    logic signed [15:0]                    start_reg, start_next;
    logic signed [15:0]                    target_reg, target_next;
    logic signed [16:0]                    w_reg, w_next;
    logic [15:0]                           m_reg, m_next;
    logic                                  pos_reg, pos_next;
    logic signed [mlfo_pkg::SAMPLE_W-1:0]  out_reg, out_next;

    logic                                  idle;
    logic                                  restart_beat;
    logic                                  mul_en;
    logic signed [mlfo_pkg::MUL_W-1:0]     mul_a, mul_b;
    logic signed [mlfo_pkg::PROD_W-1:0]    prod;

    // comb temporaries
    logic [mlfo_pkg::RS_W-1:0]             new_rs;
    logic signed [15:0]                    new_val;
    logic [23:0]                           sin_a;
    logic [24:0]                           sin_b;
    logic                                  sin_pos;
    logic [15:0]                           sin_t;
    logic [28:0]                           sin_rnd;
    logic [15:0]                           sin_mag;
    logic signed [16:0]                    rnd_diff;
    logic signed [17:0]                    rnd_sum;
    logic signed [32:0]                    scaled;
    logic                                  draw_due;

    mlfo_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .idle      (idle),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mlfo_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // waveforms that need no multiply
    function automatic logic signed [16:0] simple_wave(
        input logic [mlfo_pkg::PHASE_W-1:0] q,
        input logic [2:0]                   wave
    );
        logic [23:0]        d;
        logic signed [17:0] v;
        begin
            d = 24'd0;
            v = 18'sd0;
            case (wave)
                mlfo_pkg::WAVE_TRI: begin
                    if (q < 24'h400000) begin
                        v = $signed({1'b0, q[23:7]});
                    end else if (q < 24'hC00000) begin
                        d = q - 24'h400000;
                        v = 18'sd32768 - $signed({1'b0, d[23:7]});
                    end else begin
                        d = q - 24'hC00000;
                        v = $signed({1'b0, d[23:7]}) - 18'sd32768;
                    end
                end
                mlfo_pkg::WAVE_SAW_UP: v = $signed({2'b0, q[23:8]}) - 18'sd32768;
                mlfo_pkg::WAVE_SAW_DN: v = 18'sd32768 - $signed({2'b0, q[23:8]});
                mlfo_pkg::WAVE_SQUARE: v = (q < 24'h800000) ? 18'sd32768 : -18'sd32768;
                default:               v = 18'sd0;
            endcase
            simple_wave = v[16:0];
        end
    endfunction

    assign idle    = (state_reg == mlfo_pkg::ST_IDLE) && !cfg.seed_load;
    assign s_ready = idle;
    assign m_valid = (state_reg == mlfo_pkg::ST_OUT);
    assign m_lfo_value = out_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mlfo_pkg::ST_LOAD;
            ret_reg    <= mlfo_pkg::ST_IDLE;
            pair_reg   <= 1'b0;
            dcnt_reg   <= 1'b0;
            phase_reg  <= '0;
            interp_reg <= '0;
            rem_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            pair_reg   <= pair_next;
            dcnt_reg   <= dcnt_next;
            phase_reg  <= phase_next;
            interp_reg <= interp_next;
            rem_reg    <= rem_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rs_reg     <= rs_next;
        acc_reg    <= acc_next;
        start_reg  <= start_next;
        target_reg <= target_next;
        w_reg      <= w_next;
        m_reg      <= m_next;
        pos_reg    <= pos_next;
        out_reg    <= out_next;
    end

    // sequencer: next state, operand selection and datapath updates
    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        pair_next   = pair_reg;
        dcnt_next   = dcnt_reg;
        phase_next  = phase_reg;
        interp_next = interp_reg;
        rem_next    = rem_reg;
        rs_next     = rs_reg;
        acc_next    = acc_reg;
        start_next  = start_reg;
        target_next = target_reg;
        w_next      = w_reg;
        m_next      = m_reg;
        pos_next    = pos_reg;
        out_next    = out_reg;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;

        new_rs   = acc_reg + {prod[23:0], 24'd0};
        new_val  = $signed({~new_rs[47], new_rs[46:32]});
        sin_pos  = (phase_reg <= 24'h800000);
        sin_a    = sin_pos ? (24'h800000 - phase_reg) : (phase_reg - 24'h800000);
        sin_b    = 25'h1000000 - {sin_a, 1'b0};
        sin_t    = m_reg - prod[30:15];
        sin_rnd  = prod[28:0] + 29'd32768;
        sin_mag  = m_reg - {3'd0, sin_rnd[28:16]};
        rnd_diff = $signed({target_reg[15], target_reg}) - $signed({start_reg[15], start_reg});
        rnd_sum  = $signed({{2{start_reg[15]}}, start_reg}) + $signed(prod[41:24]);
        scaled   = $signed(prod[47:15]);
        draw_due = (phase_reg < cfg.phase_inc) && interp_reg[24];

        case (state_reg)
            // load generator from seed register, then draw start and target
            mlfo_pkg::ST_LOAD: begin
                rs_next    = cfg.seed;
                pair_next  = 1'b1;
                dcnt_next  = 1'b0;
                ret_next   = mlfo_pkg::ST_IDLE;
                state_next = mlfo_pkg::ST_DRAW0;
            end
            mlfo_pkg::ST_IDLE: begin
                if (cfg.seed_load) begin
                    state_next = mlfo_pkg::ST_LOAD;
                end else if (s_valid) begin
                    if (s_command == mlfo_pkg::CMD_RESTART) begin
                        phase_next  = '0;
                        interp_next = '0;
                        out_next    = '0;
                        pair_next   = 1'b1;
                        dcnt_next   = 1'b0;
                        ret_next    = mlfo_pkg::ST_OUT;
                        state_next  = mlfo_pkg::ST_DRAW0;
                    end else if (s_block_length == '0) begin
                        out_next   = '0;
                        state_next = mlfo_pkg::ST_OUT;
                    end else begin
                        if (int'(s_block_length) > mlfo_pkg::MAX_BLOCK) begin
                            rem_next = mlfo_pkg::REM_W'(mlfo_pkg::MAX_BLOCK - 1);
                        end else begin
                            rem_next = mlfo_pkg::REM_W'(s_block_length
                                                        - mlfo_pkg::BLEN_W'(1));
                        end
                        w_next = simple_wave(phase_reg, cfg.wave);
                        case (cfg.wave)
                            mlfo_pkg::WAVE_SINE:   state_next = mlfo_pkg::ST_SIN0;
                            mlfo_pkg::WAVE_RANDOM: state_next = mlfo_pkg::ST_RND_CHK;
                            default:               state_next = mlfo_pkg::ST_DMUL;
                        endcase
                    end
                end
            end
            // lcg step: low x low, high x low, low x high, mod 2^48
            mlfo_pkg::ST_DRAW0: begin
                mul_en     = 1'b1;
                mul_a      = $signed({2'b0, rs_reg[23:0]});
                mul_b      = $signed({2'b0, mlfo_pkg::LCG_LO});
                state_next = mlfo_pkg::ST_DRAW1;
            end
            mlfo_pkg::ST_DRAW1: begin
                mul_en     = 1'b1;
                mul_a      = $signed({2'b0, rs_reg[47:24]});
                mul_b      = $signed({2'b0, mlfo_pkg::LCG_LO});
                acc_next   = prod[47:0] + mlfo_pkg::LCG_INC;
                state_next = mlfo_pkg::ST_DRAW2;
            end
            mlfo_pkg::ST_DRAW2: begin
                mul_en     = 1'b1;
                mul_a      = $signed({2'b0, rs_reg[23:0]});
                mul_b      = $signed({15'b0, mlfo_pkg::LCG_HI});
                acc_next   = acc_reg + {prod[23:0], 24'd0};
                state_next = mlfo_pkg::ST_DRAW3;
            end
            mlfo_pkg::ST_DRAW3: begin
                rs_next = new_rs;
                if (pair_reg) begin
                    if (!dcnt_reg) begin
                        start_next = new_val;
                        dcnt_next  = 1'b1;
                        state_next = mlfo_pkg::ST_DRAW0;
                    end else begin
                        target_next = new_val;
                        state_next  = ret_reg;
                    end
                end else begin
                    start_next  = target_reg;
                    target_next = new_val;
                    interp_next = '0;
                    state_next  = ret_reg;
                end
            end
            // parabolic sine: m = a(1-2a), then m - 0.225(m - m^2)
            mlfo_pkg::ST_SIN0: begin
                mul_en     = 1'b1;
                mul_a      = $signed({2'b0, sin_a});
                mul_b      = $signed({1'b0, sin_b});
                pos_next   = sin_pos;
                state_next = mlfo_pkg::ST_SIN1;
            end
            mlfo_pkg::ST_SIN1: begin
                mul_en     = 1'b1;
                mul_a      = $signed({10'b0, prod[45:30]});
                mul_b      = $signed({10'b0, prod[45:30]});
                m_next     = prod[45:30];
                state_next = mlfo_pkg::ST_SIN2;
            end
            mlfo_pkg::ST_SIN2: begin
                mul_en     = 1'b1;
                mul_a      = $signed({10'b0, sin_t});
                mul_b      = $signed({10'b0, mlfo_pkg::SINE_K});
                state_next = mlfo_pkg::ST_SIN3;
            end
            mlfo_pkg::ST_SIN3: begin
                w_next     = pos_reg ? $signed({1'b0, sin_mag}) : -$signed({1'b0, sin_mag});
                state_next = mlfo_pkg::ST_DMUL;
            end
            // smoothed random: new target on wrap, then interpolate
            mlfo_pkg::ST_RND_CHK: begin
                if (draw_due) begin
                    pair_next  = 1'b0;
                    ret_next   = mlfo_pkg::ST_RND_CHK;
                    state_next = mlfo_pkg::ST_DRAW0;
                end else if (!interp_reg[24]) begin
                    mul_en     = 1'b1;
                    mul_a      = $signed({{9{rnd_diff[16]}}, rnd_diff});
                    mul_b      = $signed({2'b0, interp_reg[23:0]});
                    state_next = mlfo_pkg::ST_RND_VAL;
                end else begin
                    w_next     = $signed({target_reg[15], target_reg});
                    state_next = mlfo_pkg::ST_DMUL;
                end
            end
            mlfo_pkg::ST_RND_VAL: begin
                w_next      = rnd_sum[16:0];
                interp_next = interp_reg + {1'b0, cfg.interp_step};
                state_next  = mlfo_pkg::ST_DMUL;
            end
            // depth scaling of the first sample, phase moves on
            mlfo_pkg::ST_DMUL: begin
                mul_en     = 1'b1;
                mul_a      = $signed({{9{w_reg[16]}}, w_reg});
                mul_b      = $signed({10'b0, cfg.depth});
                phase_next = phase_reg + cfg.phase_inc;
                state_next = mlfo_pkg::ST_DRES;
            end
            mlfo_pkg::ST_DRES: begin
                if (scaled > 33'sd32767) begin
                    out_next = 16'sh7FFF;
                end else if (scaled < -33'sd32768) begin
                    out_next = 16'sh8000;
                end else begin
                    out_next = scaled[15:0];
                end
                state_next = mlfo_pkg::ST_ADV;
            end
            // remaining samples of the block, one per cycle unless a random draw holds them
            mlfo_pkg::ST_ADV: begin
                if (rem_reg == '0) begin
                    state_next = mlfo_pkg::ST_OUT;
                end else if ((cfg.wave == mlfo_pkg::WAVE_RANDOM) && draw_due) begin
                    pair_next  = 1'b0;
                    ret_next   = mlfo_pkg::ST_ADV;
                    state_next = mlfo_pkg::ST_DRAW0;
                end else begin
                    if ((cfg.wave == mlfo_pkg::WAVE_RANDOM) && !interp_reg[24]) begin
                        interp_next = interp_reg + {1'b0, cfg.interp_step};
                    end
                    phase_next = phase_reg + cfg.phase_inc;
                    rem_next   = rem_reg - mlfo_pkg::REM_W'(1);
                end
            end
            mlfo_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = mlfo_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mlfo_pkg::ST_IDLE;
            end
        endcase
    end

    // checks
    assign restart_beat = s_valid && s_ready && (s_command == mlfo_pkg::CMD_RESTART);

    `MLFO_ASSERT_IMP(a_in_out_excl, s_ready, !m_valid)
    `MLFO_ASSERT_NXT(a_restart_clears, restart_beat, (phase_reg == '0) && (interp_reg == '0))
    `MLFO_ASSERT_NXT(a_ready_after_beat, m_valid && m_ready, s_ready)

endmodule

`default_nettype wire
